// ----- design/rsamp_pkg.sv -----
// rsamp_pkg: shared types, register codes and the LFSR step for the
// random one-in-N packet sampler. No dependencies.
package rsamp_pkg;

	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

	typedef enum logic [2:0] {
		CFG_SAMPLE_EVERY = 3'd0,
		CFG_TRUNCATE_LEN = 3'd1,
		CFG_BL_COUNT     = 3'd2,
		CFG_BL_ADDR_A    = 3'd3,
		CFG_BL_ADDR_B    = 3'd4,
		CFG_BL_ADDR_C    = 3'd5,
		CFG_BL_ADDR_D    = 3'd6
	} cfg_idx_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [15:0] captured_length;
	} in_item_t;

	typedef struct packed {
		logic        keep;
		logic [15:0] stored_length;
		logic        blocklist_hit;
	} out_item_t;

	typedef struct packed {
		logic [23:0]      sample_every;
		logic [15:0]      truncate_len;
		logic [2:0]       blocklist_count;
		logic [3:0][31:0] blocklist_addr;
	} cfg_regs_t;

	// Galois LFSR, right shift; an all-zero register is reloaded with the seed.
	function automatic logic [31:0] lfsr_step(input logic [31:0] r);
		logic [31:0] r0;
		r0 = (r == 32'd0) ? LFSR_SEED : r;
		return (r0 >> 1) ^ (r0[0] ? LFSR_TAPS : 32'd0);
	endfunction

endpackage

// ----- design/rsamp_cfg.sv -----
// rsamp_cfg: configuration register file of the packet sampler.
// Depends on rsamp_pkg (register codes, cfg_regs_t).
module rsamp_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output rsamp_pkg::cfg_regs_t regs
);

	rsamp_pkg::cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q              <= '0;
			regs_q.sample_every <= 24'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (rsamp_pkg::cfg_idx_e'(cfg_index))
				rsamp_pkg::CFG_SAMPLE_EVERY: regs_q.sample_every    <= cfg_data[23:0];
				rsamp_pkg::CFG_TRUNCATE_LEN: regs_q.truncate_len    <= cfg_data[15:0];
				rsamp_pkg::CFG_BL_COUNT:     regs_q.blocklist_count <= cfg_data[2:0];
				rsamp_pkg::CFG_BL_ADDR_A:    regs_q.blocklist_addr[0] <= cfg_data;
				rsamp_pkg::CFG_BL_ADDR_B:    regs_q.blocklist_addr[1] <= cfg_data;
				rsamp_pkg::CFG_BL_ADDR_C:    regs_q.blocklist_addr[2] <= cfg_data;
				rsamp_pkg::CFG_BL_ADDR_D:    regs_q.blocklist_addr[3] <= cfg_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

endmodule

// ----- design/rsamp_mod.sv -----
// rsamp_mod: bit-serial restoring modulo, 32-bit dividend by 24-bit divisor,
// one quotient bit per cycle. No package dependency.
module rsamp_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [23:0] divisor,
	output logic        done,
	output logic [23:0] rem
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [23:0] div_q;
	logic [23:0] rem_q;
	logic [24:0] trial;
	logic [24:0] diff;
	logic [23:0] rem_next;

	// shift in next dividend bit, subtract when it fits
	assign trial    = {rem_q, dvd_q[31]};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = (trial >= {1'b0, div_q}) ? diff[23:0] : trial[23:0];

	assign done = done_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= rem_next;
		end
	end

endmodule

// ----- design/random_one_in_n_packet_sampler.sv -----
// random_one_in_n_packet_sampler: top level, sampling sequencer and output register.
// Depends on rsamp_pkg, rsamp_cfg and rsamp_mod.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data) takes one packet descriptor
//    per transfer: source address and captured length.
//  - Output channel (out_valid / out_stall / out_data) returns exactly one result
//    per descriptor, in order: keep flag, length to store, blocklist hit.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//    seven registers; cfg_ready is always high. Write only while idle.
//  - Output path: a descriptor that does not open a sampling window reaches the
//    output register in the cycle after its transfer. A descriptor that opens a
//    window (first of N, N >= 2, no blocklist hit) waits for the bit-serial
//    modulo unit in ST_MOD, then is loaded into the output register from ST_FIN.
//  - Throughput: one descriptor per cycle inside a window while the output is free;
//    a window start stalls input until its result loads; modulo: one bit per cycle.
//  - Reset (arst_n low) clears the window, loads the LFSR with 1, sets N to 1
//    and clears the other registers; output register empties.
//  - When the receiver stalls with a result held, in_stall rises and no new
//    descriptor is taken until that result is transferred.
module random_one_in_n_packet_sampler (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rsamp_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rsamp_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	rsamp_pkg::cfg_regs_t  regs;
	rsamp_pkg::state_t     state_q, state_d;
	rsamp_pkg::out_item_t  out_q;

	logic        out_valid_q;
	logic [23:0] wp_q;       // window position
	logic [23:0] offset_q;   // chosen offset in current window
	logic [31:0] random_q;   // LFSR
	logic [15:0] len_q;      // length held across a window-start draw

	logic        out_free;
	logic        in_acc;
	logic        hit;
	logic        n_is_one;
	logic        window_active;
	logic        need_draw;
	logic        ld_fast;
	logic        ld_fin;
	logic        ld_out;
	logic        wp_adv;
	logic [23:0] wp_inc;
	logic [23:0] wp_d;
	logic [31:0] lfsr_next;
	logic        cur_keep;
	logic        cur_hit;
	logic [15:0] cur_len;
	logic [15:0] cur_stored;
	logic        mod_done;
	logic [23:0] mod_rem;

	rsamp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// modulo unit: offset = lfsr % N
	rsamp_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (need_draw),
		.dividend (lfsr_next),
		.divisor  (regs.sample_every),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// blocklist match; counts above four behave as four
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if ((regs.blocklist_count > 3'(i)) &&
			    (regs.blocklist_addr[i] == in_data.source_address)) begin
				hit = 1'b1;
			end
		end
	end

	assign n_is_one      = (regs.sample_every <= 24'd1);   // N of 0 acts as 1
	assign window_active = !hit && !n_is_one;
	assign lfsr_next     = rsamp_pkg::lfsr_step(random_q);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != rsamp_pkg::ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// first packet of a window needs a fresh offset
	assign need_draw = in_acc && window_active && (wp_q == 24'd0);
	assign ld_fast   = in_acc && !need_draw;
	assign ld_fin    = (state_q == rsamp_pkg::ST_FIN) && out_free;
	assign ld_out    = ld_fast || ld_fin;
	assign wp_adv    = (ld_fast && window_active) || ld_fin;

	assign wp_inc = wp_q + 24'd1;
	assign wp_d   = (wp_inc >= regs.sample_every) ? 24'd0 : wp_inc;

	always_comb begin
		if (ld_fin) begin
			cur_keep = (wp_q == offset_q);
			cur_hit  = 1'b0;
			cur_len  = len_q;
		end else begin
			cur_keep = !window_active || (wp_q == offset_q);
			cur_hit  = hit;
			cur_len  = in_data.captured_length;
		end
		cur_stored = 16'd0;
		if (cur_keep) begin
			cur_stored = ((regs.truncate_len != 16'd0) && (cur_len > regs.truncate_len)) ?
				regs.truncate_len : cur_len;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsamp_pkg::ST_IDLE: if (need_draw) state_d = rsamp_pkg::ST_MOD;
			rsamp_pkg::ST_MOD:  if (mod_done)  state_d = rsamp_pkg::ST_FIN;
			rsamp_pkg::ST_FIN:  if (out_free)  state_d = rsamp_pkg::ST_IDLE;
			default:            state_d = rsamp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsamp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			offset_q    <= '0;
			random_q    <= rsamp_pkg::LFSR_SEED;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wp_adv)    wp_q     <= wp_d;
			if (mod_done)  offset_q <= mod_rem;
			if (need_draw) random_q <= lfsr_next;
		end
	end

	always_ff @(posedge clk) begin
		if (need_draw) len_q <= in_data.captured_length;
		if (ld_out) begin
			out_q.keep          <= cur_keep;
			out_q.stored_length <= cur_stored;
			out_q.blocklist_hit <= cur_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// modulo completion only while the sequencer waits for it
	a_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == rsamp_pkg::ST_MOD))
		else $error("modulo done outside draw state");

	// LFSR never reaches the all-zero lockup state
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		random_q != 32'd0)
		else $error("LFSR is zero");

	// a window start parks the sequencer in the draw state next cycle
	a_draw_enters_mod: assert property (@(posedge clk) disable iff (!arst_n)
		need_draw |=> (state_q == rsamp_pkg::ST_MOD))
		else $error("window start did not enter draw");

	// dropped packets store nothing; a blocklist hit is always kept
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.keep) |-> (out_q.stored_length == 16'd0 && !out_q.blocklist_hit))
		else $error("dropped result carries length or hit");

endmodule
